/* design/hcm_pkg.sv */
// ----------------------------------------------------------------------------
// hcm_pkg
// Shared types and codes for the heat color map pipeline.
// ----------------------------------------------------------------------------
package hcm_pkg;

   // Control that travels with every pipeline stage.
   typedef struct packed {
      logic valid;
      logic bad;
   } hcm_ctl_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SCALE_LOW  = 2'd0,
      CSR_SCALE_HIGH = 2'd1
   } csr_index_type;

   // Ramp segments: blue->green, green->yellow, yellow->red.
   typedef enum logic [1:0] {
      SEG_BLUE_GREEN   = 2'd0,
      SEG_GREEN_YELLOW = 2'd1,
      SEG_YELLOW_RED   = 2'd2
   } seg_type;

   localparam logic [7:0] CHAN_FULL = 8'hFF;
   localparam logic [7:0] CHAN_OFF  = 8'h00;

endpackage

/* design/hcm_range_front.sv */
// ----------------------------------------------------------------------------
// hcm_range_front
// Clamps the sample to the scale and forms its offset above scale_low.
// ----------------------------------------------------------------------------
module hcm_range_front import hcm_pkg::*; #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] scale_low,
   input  logic signed [SAMPLE_BITS-1:0] scale_high,
   output hcm_ctl_type                   ctl,
   output logic        [SAMPLE_BITS:0]   offset
);

   hcm_ctl_type                   ctl_ff, ctl_in;
   logic        [SAMPLE_BITS:0]   offset_ff, offset_in;
   logic signed [SAMPLE_BITS-1:0] clamped;

   always_comb begin
      ctl_in.valid = accept;
      ctl_in.bad   = !(scale_high > scale_low);
      if (sample < scale_low) begin
         clamped = scale_low;
      end else if (sample > scale_high) begin
         clamped = scale_high;
      end else begin
         clamped = sample;
      end
      // offset is never negative once clamped
      if (ctl_in.bad) begin
         offset_in = '0;
      end else begin
         offset_in = {clamped[SAMPLE_BITS-1], clamped}
                   - {scale_low[SAMPLE_BITS-1], scale_low};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.bad <= ctl_in.bad;
      offset_ff  <= offset_in;
   end

   assign ctl    = ctl_ff;
   assign offset = offset_ff;

endmodule

/* design/hcm_div_stage.sv */
// ----------------------------------------------------------------------------
// hcm_div_stage
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module hcm_div_stage import hcm_pkg::*; #(
   parameter int SAMPLE_BITS = 24,
   parameter int QUO_BITS    = 17,
   parameter bit FIRST       = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hcm_ctl_type          ctl_i,
   input  logic [SAMPLE_BITS:0] rem_i,
   input  logic [QUO_BITS-1:0]  quo_i,
   input  logic [SAMPLE_BITS:0] span,
   output hcm_ctl_type          ctl_o,
   output logic [SAMPLE_BITS:0] rem_o,
   output logic [QUO_BITS-1:0]  quo_o
);

   hcm_ctl_type                ctl_ff;
   logic [SAMPLE_BITS:0]       rem_ff, rem_in;
   logic [QUO_BITS-1:0]        quo_ff, quo_in;
   logic [SAMPLE_BITS+1:0]     trial, diff;
   logic                       take;

   always_comb begin
      // integer bit first, then shift in one fraction bit per stage
      trial  = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
      diff   = trial - {1'b0, span};
      take   = (trial >= {1'b0, span});
      rem_in = take ? diff[SAMPLE_BITS:0] : trial[SAMPLE_BITS:0];
      quo_in = {quo_i[QUO_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_i.valid;
      end
      ctl_ff.bad <= ctl_i.bad;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign quo_o = quo_ff;

endmodule

/* design/hcm_color_mix.sv */
// ----------------------------------------------------------------------------
// hcm_color_mix
// Segment lookup and per-channel linear mix, five register stages.
// ----------------------------------------------------------------------------
module hcm_color_mix import hcm_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hcm_ctl_type            ctl_i,
   input  logic [FRACTION_BITS:0] frac,
   output logic                   out_valid,
   output logic [7:0]             out_red,
   output logic [7:0]             out_green,
   output logic [7:0]             out_blue,
   output logic                   out_bad
);

   localparam int     FB    = FRACTION_BITS;
   localparam longint FONE  = longint'(1) << FB;
   localparam longint STOP1 = (FONE * 2) / 5;
   localparam longint STOP2 = (FONE * 7) / 10;
   localparam longint W0    = STOP1;
   localparam longint W1    = STOP2 - STOP1;
   localparam longint W2    = FONE - STOP2;
   localparam int     K     = FB + 8;
   // reciprocals rounded up; error stays below one unit for 255*t < 2^K
   localparam longint R0    = ((longint'(1) << K) + W0 - 1) / W0;
   localparam longint R1    = ((longint'(1) << K) + W1 - 1) / W1;
   localparam longint R2    = ((longint'(1) << K) + W2 - 1) / W2;
   localparam longint R01   = (R0 > R1) ? R0 : R1;
   localparam longint R_MAX = (R01 > R2) ? R01 : R2;
   localparam int     RW    = $clog2(R_MAX + 1);
   localparam int     XW    = FB + 8;
   localparam int     PW    = XW + RW;

   // stage 1: segment and distances to its ends
   hcm_ctl_type     c1_ff, c2_ff, c3_ff, c4_ff;
   seg_type         s1_ff, s2_ff, s3_ff, s4_ff, seg_in;
   logic [FB:0]     f, lo_b, hi_b;
   logic [FB-1:0]   tu_ff, td_ff, tu_in, td_in;
   // stage 2: times 255
   logic [XW-1:0]   xu2_ff, xd2_ff, xu2_in, xd2_in;
   // stage 3: reciprocal multiply
   logic [RW-1:0]   r_sel;
   logic [PW-1:0]   pu, pd;
   logic [7:0]      qu3_ff, qd3_ff, qu3_in, qd3_in;
   logic [XW-1:0]   xu3_ff, xd3_ff;
   // stage 4: back-multiply for correction
   logic [FB-1:0]   w_sel;
   logic [XW-1:0]   mu4_ff, md4_ff, mu4_in, md4_in;
   logic [7:0]      qu4_ff, qd4_ff;
   logic [XW-1:0]   xu4_ff, xd4_ff;
   // stage 5: correct and assemble
   logic [7:0]      up, down;
   logic            valid_ff;
   logic [7:0]      red_ff, green_ff, blue_ff, red_in, green_in, blue_in;
   logic            bad_ff;

   always_comb begin
      f = ctl_i.bad ? '0 : frac;
      priority if (f <= (FB+1)'(STOP1)) begin
         seg_in = SEG_BLUE_GREEN;
      end else if (f <= (FB+1)'(STOP2)) begin
         seg_in = SEG_GREEN_YELLOW;
      end else begin
         seg_in = SEG_YELLOW_RED;
      end
      unique case (seg_in)
         SEG_BLUE_GREEN: begin
            lo_b = '0;
            hi_b = (FB+1)'(STOP1);
         end
         SEG_GREEN_YELLOW: begin
            lo_b = (FB+1)'(STOP1);
            hi_b = (FB+1)'(STOP2);
         end
         default: begin
            lo_b = (FB+1)'(STOP2);
            hi_b = (FB+1)'(FONE);
         end
      endcase
      tu_in = FB'(f - lo_b);
      td_in = FB'(hi_b - f);
   end

   always_comb begin
      xu2_in = {tu_ff, 8'h00} - {8'h00, tu_ff};
      xd2_in = {td_ff, 8'h00} - {8'h00, td_ff};
   end

   always_comb begin
      unique case (s2_ff)
         SEG_BLUE_GREEN:   r_sel = RW'(R0);
         SEG_GREEN_YELLOW: r_sel = RW'(R1);
         default:          r_sel = RW'(R2);
      endcase
      pu     = PW'(xu2_ff) * PW'(r_sel);
      pd     = PW'(xd2_ff) * PW'(r_sel);
      qu3_in = pu[K +: 8];
      qd3_in = pd[K +: 8];
   end

   always_comb begin
      unique case (s3_ff)
         SEG_BLUE_GREEN:   w_sel = FB'(W0);
         SEG_GREEN_YELLOW: w_sel = FB'(W1);
         default:          w_sel = FB'(W2);
      endcase
      mu4_in = XW'(qu3_ff) * XW'(w_sel);
      md4_in = XW'(qd3_ff) * XW'(w_sel);
   end

   always_comb begin
      // estimate is exact or one too high
      up   = (mu4_ff > xu4_ff) ? qu4_ff - 8'd1 : qu4_ff;
      down = (md4_ff > xd4_ff) ? qd4_ff - 8'd1 : qd4_ff;
      unique case (s4_ff)
         SEG_BLUE_GREEN: begin
            red_in   = CHAN_OFF;
            green_in = up;
            blue_in  = down;
         end
         SEG_GREEN_YELLOW: begin
            red_in   = up;
            green_in = CHAN_FULL;
            blue_in  = CHAN_OFF;
         end
         default: begin
            red_in   = CHAN_FULL;
            green_in = down;
            blue_in  = CHAN_OFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         c2_ff.valid <= 1'b0;
         c3_ff.valid <= 1'b0;
         c4_ff.valid <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         c1_ff.valid <= ctl_i.valid;
         c2_ff.valid <= c1_ff.valid;
         c3_ff.valid <= c2_ff.valid;
         c4_ff.valid <= c3_ff.valid;
         valid_ff    <= c4_ff.valid;
      end
      c1_ff.bad <= ctl_i.bad;
      c2_ff.bad <= c1_ff.bad;
      c3_ff.bad <= c2_ff.bad;
      c4_ff.bad <= c3_ff.bad;
      bad_ff    <= c4_ff.bad;
      s1_ff     <= seg_in;
      s2_ff     <= s1_ff;
      s3_ff     <= s2_ff;
      s4_ff     <= s3_ff;
      tu_ff     <= tu_in;
      td_ff     <= td_in;
      xu2_ff    <= xu2_in;
      xd2_ff    <= xd2_in;
      qu3_ff    <= qu3_in;
      qd3_ff    <= qd3_in;
      xu3_ff    <= xu2_ff;
      xd3_ff    <= xd2_ff;
      mu4_ff    <= mu4_in;
      md4_ff    <= md4_in;
      qu4_ff    <= qu3_ff;
      qd4_ff    <= qd3_ff;
      xu4_ff    <= xu3_ff;
      xd4_ff    <= xd3_ff;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;
   assign out_bad   = bad_ff;

endmodule

/* design/heat_color_map_core.sv */
// ----------------------------------------------------------------------------
// heat_color_map_core
// False-color map of one signed sample onto a blue-green-yellow-red ramp.
// ----------------------------------------------------------------------------
// Usage: a request is taken on every clock in which start is high and busy is
// low; busy is raised only by reset and clears once reset is released. Each
// request yields one color, shown for a single cycle with rsp_valid high. The
// receiver cannot stall, so results must be taken as they appear. Sustained
// rate is one request per clock; the pipeline is the long divider (one
// quotient bit per stage, FRACTION_BITS+1 stages), plus one clamp stage and
// five mix stages. Write scale_low / scale_high only while no request is in
// flight. If scale_high is not above scale_low the color is pure blue and
// rsp_bad_range is set.
// ----------------------------------------------------------------------------
module heat_color_map_core import hcm_pkg::*; #(
   parameter int SAMPLE_BITS   = 24,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // result channel
   output logic                          rsp_valid,
   output logic        [7:0]             rsp_red,
   output logic        [7:0]             rsp_green,
   output logic        [7:0]             rsp_blue,
   output logic                          rsp_bad_range,
   // register write port
   input  logic                          csr_write,
   input  logic        [1:0]             csr_index,
   input  logic        [SAMPLE_BITS-1:0] csr_wdata
);

   localparam int QUO_BITS = FRACTION_BITS + 1;
   localparam int LATENCY  = FRACTION_BITS + 7;

   // ---- configuration registers -------------------------------------------
   logic signed [SAMPLE_BITS-1:0] scale_low_ff, scale_high_ff;
   logic        [SAMPLE_BITS:0]   span_ff, span_in;
   logic                          busy_ff;
   logic                          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_low_ff  <= '0;
         scale_high_ff <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCALE_LOW:  scale_low_ff  <= csr_wdata;
            CSR_SCALE_HIGH: scale_high_ff <= csr_wdata;
            default: ;  // unused indexes are dropped
         endcase
      end
   end

   // Divisor is a static function of the registers; span_ff takes a write in
   // the next cycle, ahead of the first divider stage a new request reaches.
   assign span_in = {scale_high_ff[SAMPLE_BITS-1], scale_high_ff}
                  - {scale_low_ff[SAMPLE_BITS-1], scale_low_ff};

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // ---- clamp and offset ---------------------------------------------------
   hcm_ctl_type                ctl_q [0:QUO_BITS];
   logic        [SAMPLE_BITS:0] rem_q [0:QUO_BITS];
   logic        [QUO_BITS-1:0]  quo_q [0:QUO_BITS];

   hcm_range_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (req_sample),
      .scale_low  (scale_low_ff),
      .scale_high (scale_high_ff),
      .ctl        (ctl_q[0]),
      .offset     (rem_q[0])
   );

   assign quo_q[0] = '0;

   // ---- fraction = offset * 2^FRACTION_BITS / span, one bit per stage -----
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      hcm_div_stage #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .QUO_BITS    (QUO_BITS),
         .FIRST       (i == 0)
      ) u_step (
         .clock (clock),
         .reset (reset),
         .ctl_i (ctl_q[i]),
         .rem_i (rem_q[i]),
         .quo_i (quo_q[i]),
         .span  (span_ff),
         .ctl_o (ctl_q[i+1]),
         .rem_o (rem_q[i+1]),
         .quo_o (quo_q[i+1])
      );
   end

   // ---- segment select and channel interpolation ---------------------------
   hcm_color_mix #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .ctl_i     (ctl_q[QUO_BITS]),
      .frac      (quo_q[QUO_BITS]),
      .out_valid (rsp_valid),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue),
      .out_bad   (rsp_bad_range)
   );

   // ---- checks -------------------------------------------------------------
   // every result traces back to an earlier accepted request
   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result without matching request");

   // blue and red never light together anywhere on the ramp
   a_no_blue_and_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_blue == CHAN_OFF || rsp_red == CHAN_OFF))
      else $error("blue and red both lit");

   // an unusable scale maps to pure blue
   a_bad_range_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_range |->
         rsp_blue == CHAN_FULL && rsp_red == CHAN_OFF && rsp_green == CHAN_OFF)
      else $error("bad range result is not blue");

   // divider front never carries an offset when the range is unusable
   a_bad_zero_offset: assert property (@(posedge clock) disable iff (reset)
      ctl_q[0].valid && ctl_q[0].bad |-> rem_q[0] == '0)
      else $error("offset not cleared for bad range");

endmodule
